// ----- rtl/core/pwd_pkg.sv -----
// Shared types and constants for the pairwise Euclidean distance core.
// No dependencies; used by pwd_front, pwd_sqrt, pwd_back and the top-level core.
package pwd_pkg;

  localparam int unsigned MaxPoints  = 16;
  localparam int unsigned MaxDims    = 16;
  localparam int unsigned CoordBits  = 16;
  localparam int unsigned PtBits     = 4;
  localparam int unsigned DimBits    = 4;
  localparam int unsigned CfgBits    = 5;
  localparam int unsigned NormBits   = 35;
  localparam int unsigned DotBits    = 36;
  localparam int unsigned SqBits     = 2 * CoordBits;
  localparam int unsigned D2Bits     = 39;
  localparam int unsigned RadBits    = 38;
  localparam int unsigned RootBits   = 19;
  localparam int unsigned DistBits   = 18;
  localparam int unsigned RamDepth   = MaxPoints * MaxDims;

  // Configuration register indexes
  localparam logic [1:0] CFG_POINTS_USED = 2'd0;
  localparam logic [1:0] CFG_DIMS_USED   = 2'd1;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } item_kind_e;

  // One classified item in the queue between front and back
  typedef struct packed {
    item_kind_e                    kind;
    logic                          last;
    logic [PtBits-1:0]             pt;
    logic [DimBits-1:0]            dim;
    logic signed [CoordBits-1:0]   value;
  } item_t;

  // Clamp a configuration value to 1..16
  function automatic logic [CfgBits-1:0] clamp_cfg(logic [CfgBits-1:0] v);
    logic [CfgBits-1:0] r;
    if (v == '0) r = CfgBits'(1);
    else if (v > CfgBits'(16)) r = CfgBits'(16);
    else r = v;
    return r;
  endfunction

endpackage

// ----- rtl/core/pwd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pwd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/pwd_front.sv -----
// Front end: accepts input items, classifies them and queues them for the back end.
// Depends on pwd_pkg.
module pwd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           in_cmd_i,
  input  logic [pwd_pkg::PtBits-1:0]     in_pt_i,
  input  logic [pwd_pkg::DimBits-1:0]    in_dim_i,
  input  logic [pwd_pkg::CoordBits-1:0]  in_value_i,
  input  logic [pwd_pkg::CfgBits-1:0]    dims_used_i,
  output logic                           item_valid_o,
  output pwd_pkg::item_t                 item_o,
  input  logic                           item_pop_i
);

  pwd_pkg::item_t          fifo_q [2];
  logic                    wptr_q, rptr_q;
  logic [1:0]              cnt_q;
  pwd_pkg::item_t          new_item;
  logic [pwd_pkg::CfgBits-1:0] nd;
  logic                    push;
  logic                    pop;

  // Classify: query items on the final coordinate trigger the distance pass
  always_comb begin
    nd = pwd_pkg::clamp_cfg(dims_used_i);
    new_item.kind  = in_cmd_i ? pwd_pkg::KIND_QUERY : pwd_pkg::KIND_LOAD;
    new_item.last  = in_cmd_i && ({1'b0, in_dim_i} == (nd - pwd_pkg::CfgBits'(1)));
    new_item.pt    = in_pt_i;
    new_item.dim   = in_dim_i;
    new_item.value = $signed(in_value_i);
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = fifo_q[rptr_q];

  // Two-entry queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wptr_q] <= new_item;
  end

endmodule

// ----- rtl/core/pwd_sqrt.sv -----
// Iterative floor square root, two radicand bits per cycle.
// Depends on pwd_pkg.
module pwd_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pwd_pkg::RadBits-1:0]   radicand_i,
  output logic                          done_o,
  output logic [pwd_pkg::RootBits-1:0]  root_o
);

  localparam int unsigned RemBits = pwd_pkg::RootBits + 3;

  logic [pwd_pkg::RadBits-1:0]  x_q;
  logic [RemBits-1:0]           rem_q;
  logic [pwd_pkg::RootBits-1:0] root_q;
  logic [4:0]                   cnt_q;
  logic                         busy_q, done_q;
  logic [RemBits-1:0]           rem_t, trial;

  // One root bit per step
  always_comb begin
    rem_t = {rem_q[RemBits-3:0], x_q[pwd_pkg::RadBits-1 -: 2]};
    trial = {1'b0, root_q, 2'b01};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(pwd_pkg::RootBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q <= {x_q[pwd_pkg::RadBits-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_q  <= rem_t - trial;
        root_q <= {root_q[pwd_pkg::RootBits-2:0], 1'b1};
      end else begin
        rem_q  <= rem_t;
        root_q <= {root_q[pwd_pkg::RootBits-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- rtl/core/pwd_back.sv -----
// Back end: reference loads, dot-product sweep over stored points, distance output.
// Depends on pwd_pkg, pwd_ram and pwd_sqrt.
module pwd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_valid_i,
  input  pwd_pkg::item_t                item_i,
  output logic                          item_pop_o,
  input  logic [pwd_pkg::CfgBits-1:0]   points_used_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pwd_pkg::PtBits-1:0]    out_pt_o,
  output logic [pwd_pkg::DistBits-1:0]  out_dist_o,
  output logic                          out_last_o
);

  localparam int unsigned AW = $clog2(pwd_pkg::RamDepth);
  localparam int unsigned PB = pwd_pkg::PtBits;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOAD  = 7'b0000010,
    ST_QUERY = 7'b0000100,
    ST_DOT   = 7'b0001000,
    ST_DIST  = 7'b0010000,
    ST_SQRT  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e                              state_q, state_d;
  pwd_pkg::item_t                      item_q;
  logic [pwd_pkg::SqBits-1:0]          sq_q;
  logic [pwd_pkg::NormBits-1:0]        norm_q [pwd_pkg::MaxPoints];
  logic signed [pwd_pkg::DotBits-1:0]  dot_q [pwd_pkg::MaxPoints];
  logic [pwd_pkg::NormBits-1:0]        qnorm_q;
  logic [PB:0]                         iss_q;
  logic                                v1_q, v2_q;
  logic [PB-1:0]                       idx1_q, idx2_q;
  logic signed [pwd_pkg::SqBits-1:0]   prod_q;
  logic [PB-1:0]                       pcnt_q;
  logic signed [pwd_pkg::D2Bits-1:0]   d2_q;
  logic                                sq_start_q;
  logic                                out_valid_q, out_last_q;
  logic [PB-1:0]                       out_pt_q;
  logic [pwd_pkg::DistBits-1:0]        out_dist_q;

  logic [pwd_pkg::CfgBits-1:0]         np;
  logic                                issue, dot_done, out_free, sq_start, sq_done;
  logic [pwd_pkg::CoordBits-1:0]       ram_rdata;
  logic [pwd_pkg::RootBits-1:0]        root;
  logic [pwd_pkg::NormBits:0]          norm_sum, qnorm_sum;
  logic signed [pwd_pkg::DotBits:0]    dot_sum;
  logic [pwd_pkg::RadBits-1:0]         radicand;

  assign np       = pwd_pkg::clamp_cfg(points_used_i);
  assign issue    = (state_q == ST_DOT) && !iss_q[PB];
  assign dot_done = (state_q == ST_DOT) && iss_q[PB] && !v1_q && !v2_q;
  assign out_free = !out_valid_q || out_ready_i;
  // Root starts on the first SQRT cycle, once d2_q holds the squared distance
  assign sq_start = sq_start_q;
  assign item_pop_o = (state_q == ST_IDLE) && item_valid_i;
  assign radicand = d2_q[pwd_pkg::D2Bits-1] ? '0 : d2_q[pwd_pkg::RadBits-1:0];

  pwd_ram #(
    .WIDTH(pwd_pkg::CoordBits),
    .DEPTH(pwd_pkg::RamDepth)
  ) u_coords (
    .clk_i  (clk_i),
    .we_i   (state_q == ST_LOAD),
    .waddr_i(AW'({item_q.pt, item_q.dim})),
    .wdata_i(item_q.value),
    .re_i   (issue),
    .raddr_i(AW'({iss_q[PB-1:0], item_q.dim})),
    .rdata_o(ram_rdata)
  );

  pwd_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sq_start),
    .radicand_i(radicand),
    .done_o    (sq_done),
    .root_o    (root)
  );

  // Saturating adders for norms and the dot accumulator
  always_comb begin
    norm_sum  = {1'b0, norm_q[item_q.pt]} + (pwd_pkg::NormBits+1)'(sq_q);
    qnorm_sum = {1'b0, qnorm_q} + (pwd_pkg::NormBits+1)'(sq_q);
    dot_sum   = (pwd_pkg::DotBits+1)'(dot_q[idx2_q]) + (pwd_pkg::DotBits+1)'(prod_q);
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          state_d = (item_i.kind == pwd_pkg::KIND_LOAD) ? ST_LOAD : ST_QUERY;
        end
      end
      ST_LOAD:  state_d = ST_IDLE;
      ST_QUERY: state_d = ST_DOT;
      ST_DOT: begin
        if (dot_done) state_d = item_q.last ? ST_DIST : ST_IDLE;
      end
      ST_DIST: state_d = ST_SQRT;
      ST_SQRT: begin
        if (sq_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ({1'b0, pcnt_q} == np - pwd_pkg::CfgBits'(1)) ? ST_IDLE : ST_DIST;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      qnorm_q     <= '0;
      iss_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      pcnt_q      <= '0;
      sq_start_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < pwd_pkg::MaxPoints; i++) begin
        norm_q[i] <= '0;
        dot_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      sq_start_q <= (state_q == ST_DIST);
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      // Reference load: restart or extend the point's norm
      if (state_q == ST_LOAD) begin
        if (item_q.dim == '0) norm_q[item_q.pt] <= pwd_pkg::NormBits'(sq_q);
        else if (norm_sum[pwd_pkg::NormBits]) norm_q[item_q.pt] <= '1;
        else norm_q[item_q.pt] <= norm_sum[pwd_pkg::NormBits-1:0];
      end

      // Query coordinate: update the query norm, clear dots on a restart
      if (state_q == ST_QUERY) begin
        iss_q <= '0;
        if (item_q.dim == '0) begin
          qnorm_q <= pwd_pkg::NormBits'(sq_q);
          for (int i = 0; i < pwd_pkg::MaxPoints; i++) dot_q[i] <= '0;
        end else if (qnorm_sum[pwd_pkg::NormBits]) begin
          qnorm_q <= '1;
        end else begin
          qnorm_q <= qnorm_sum[pwd_pkg::NormBits-1:0];
        end
      end

      // Dot sweep pipeline: read, multiply, accumulate
      if (issue) iss_q <= iss_q + (PB+1)'(1);
      v1_q <= issue;
      v2_q <= v1_q;
      if (v2_q) begin
        if (dot_sum[pwd_pkg::DotBits] != dot_sum[pwd_pkg::DotBits-1]) begin
          dot_q[idx2_q] <= dot_sum[pwd_pkg::DotBits]
                         ? {1'b1, {(pwd_pkg::DotBits-1){1'b0}}}
                         : {1'b0, {(pwd_pkg::DotBits-1){1'b1}}};
        end else begin
          dot_q[idx2_q] <= dot_sum[pwd_pkg::DotBits-1:0];
        end
      end

      if (dot_done) pcnt_q <= '0;

      // Distance result into the output register
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
        pcnt_q      <= pcnt_q + PB'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      item_q <= item_i;
      sq_q   <= pwd_pkg::SqBits'($signed(item_i.value) * $signed(item_i.value));
    end
    idx1_q <= iss_q[PB-1:0];
    idx2_q <= idx1_q;
    if (v1_q) prod_q <= $signed(ram_rdata) * item_q.value;
    if (state_q == ST_DIST) begin
      d2_q <= $signed({4'b0, norm_q[pcnt_q]}) + $signed({4'b0, qnorm_q})
            - ($signed({{3{dot_q[pcnt_q][pwd_pkg::DotBits-1]}}, dot_q[pcnt_q]}) <<< 1);
    end
    if ((state_q == ST_OUT) && out_free) begin
      out_pt_q   <= pcnt_q;
      out_dist_q <= root[pwd_pkg::RootBits-1] ? '1 : root[pwd_pkg::DistBits-1:0];
      out_last_q <= ({1'b0, pcnt_q} == np - pwd_pkg::CfgBits'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pt_o    = out_pt_q;
  assign out_dist_o  = out_dist_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- rtl/core/pairwise_euclidean_distance_core.sv -----
// Pairwise Euclidean distance core: stored reference points against streamed queries.
// Depends on pwd_pkg, pwd_front and pwd_back.
//
// Input stream (s_axis): tuser selects a reference load (0) or a query coordinate (1).
// A load stores one coordinate of a reference point and updates its squared norm.
// Query coordinates accumulate the query norm and one dot product per stored point;
// the coordinate at dims_used-1 then emits one distance per point 0..points_used-1
// on m_axis in ascending order, tlast on the final one.
// Every query coordinate sweeps all 16 stored points through the coordinate RAM read
// port and multiplier. Each distance then spends most of its time in the iterative
// square root unit. A two-entry queue separates the front from the back; an output
// register holds a finished result, so a stalled receiver only stops the back once
// its next result is ready. Reset clears norms, dot products and the queue;
// coordinates stored in RAM are undefined until loaded. Configuration (cfg_*) must
// be written only while the core is idle; the core itself does not enforce this.
// points_used and dims_used reset to 16.
module pairwise_euclidean_distance_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // point_index[3:0], dim_index[7:4], coord_value[23:8]
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // ref_point[3:0], distance[21:4], zero pad[23:22]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  logic [pwd_pkg::CfgBits-1:0]  points_used_q, dims_used_q;
  logic                         item_valid, item_pop;
  pwd_pkg::item_t               item;
  logic [pwd_pkg::PtBits-1:0]   out_pt;
  logic [pwd_pkg::DistBits-1:0] out_dist;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_used_q <= pwd_pkg::CfgBits'(16);
      dims_used_q   <= pwd_pkg::CfgBits'(16);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pwd_pkg::CFG_POINTS_USED: points_used_q <= cfg_data_i;
        pwd_pkg::CFG_DIMS_USED:   dims_used_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pwd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_pt_i     (s_axis_tdata[3:0]),
    .in_dim_i    (s_axis_tdata[7:4]),
    .in_value_i  (s_axis_tdata[23:8]),
    .dims_used_i (dims_used_q),
    .item_valid_o(item_valid),
    .item_o      (item),
    .item_pop_i  (item_pop)
  );

  pwd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .points_used_i(points_used_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_pt_o     (out_pt),
    .out_dist_o   (out_dist),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_dist, out_pt};

endmodule

// ----- test/tb_pairwise_euclidean_distance_core.sv -----
// Self-checking testbench for pairwise_euclidean_distance_core.
// Depends on pwd_pkg and the core; the expected distances come from a predictor in this file.
`timescale 1ns / 100ps

module tb_pairwise_euclidean_distance_core;

  localparam longint NormSat = 64'd34359738367;
  localparam longint DotHi   = 64'd34359738367;
  localparam longint DotLo   = -64'sd34359738368;
  localparam longint DistSat = 262143;
  localparam int     RandItems = 100;
  localparam int     DrainCycles = 120;

  typedef struct {
    logic [pwd_pkg::PtBits-1:0]   pt;
    logic [pwd_pkg::DistBits-1:0] distance;
    logic                         last;
  } dist_rec_t;

  // One row of the directed stimulus; typed rows carry the distances of points 0 and 1
  typedef struct {
    pwd_pkg::item_kind_e kind;
    logic [3:0]          pt;
    logic [3:0]          dim;
    logic signed [15:0]  value;
    bit                  typed;
    int                  dist0;
    int                  dist1;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // point_index[3:0], dim_index[7:4], coord_value[23:8]
  logic        s_axis_tuser;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // ref_point[3:0], distance[21:4]
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [4:0]  cfg_data_i;

  pairwise_euclidean_distance_core dut (.*);

  // Predictor state
  longint    coords [pwd_pkg::MaxPoints][pwd_pkg::MaxDims];
  longint    norms  [pwd_pkg::MaxPoints];
  longint    dots   [pwd_pkg::MaxPoints];
  longint    qnorm;
  logic [4:0] points_raw;
  logic [4:0] dims_raw;
  dist_rec_t dist_q[$];

  int  errors;
  int  results_seen;
  bit  calm;
  int  stall_left;
  bit  long_hold_done;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic longint clamp_used(logic [4:0] v);
    if (v == 0) return 1;
    if (v > 16) return 16;
    return v;
  endfunction

  function automatic longint floor_root(longint x);
    longint r;
    longint t;
    r = 0;
    for (int i = 20; i >= 0; i--) begin
      t = r | (longint'(1) << i);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic longint sat_dot(longint v);
    if (v > DotHi) return DotHi;
    if (v < DotLo) return DotLo;
    return v;
  endfunction

  // Update the predicted state for one accepted item and queue the distances it causes
  function automatic void predict_distances(pwd_pkg::item_kind_e kind, logic [3:0] pt,
                                            logic [3:0] dim, logic signed [15:0] value);
    longint v;
    longint sq;
    longint np;
    longint d2;
    longint dist_v;
    dist_rec_t rec;
    v  = value;
    sq = v * v;
    if (kind == pwd_pkg::KIND_LOAD) begin
      coords[pt][dim] = v;
      if (dim == 0) norms[pt] = sq;
      else norms[pt] = norms[pt] + sq;
      if (norms[pt] > NormSat) norms[pt] = NormSat;
      return;
    end
    if (dim == 0) begin
      qnorm = 0;
      foreach (dots[p]) dots[p] = 0;
    end
    qnorm = qnorm + sq;
    if (qnorm > NormSat) qnorm = NormSat;
    foreach (dots[p]) dots[p] = sat_dot(dots[p] + coords[p][dim] * v);
    if (longint'(dim) != clamp_used(dims_raw) - 1) return;
    np = clamp_used(points_raw);
    for (int p = 0; p < np; p++) begin
      d2     = norms[p] + qnorm - 2 * dots[p];
      dist_v = (d2 > 0) ? floor_root(d2) : 0;
      if (dist_v > DistSat) dist_v = DistSat;
      rec.pt       = pwd_pkg::PtBits'(p);
      rec.distance = pwd_pkg::DistBits'(dist_v);
      rec.last     = (p == np - 1);
      dist_q.push_back(rec);
    end
  endfunction

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [15:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh7FFF;
    if (r == 2) return 16'sh0000;
    if (r == 3) return 16'shFFFF;
    return 16'($urandom);
  endfunction

  // Offer one item and hold it until the core takes it
  task automatic send_item(pwd_pkg::item_kind_e kind, logic [3:0] pt, logic [3:0] dim,
                           logic signed [15:0] value);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {value, dim, pt};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_distances(kind, pt, dim, value);
  endtask

  // Wait for all distances, let the core finish internal work, then write one register
  task automatic write_cfg(logic [1:0] index, logic [4:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (dist_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (index == pwd_pkg::CFG_POINTS_USED) points_raw = value;
    else dims_raw = value;
  endtask

  function automatic logic [4:0] rand_cfg();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 5'd0;
    if (r == 1) return 5'd31;
    if (r == 2) return 5'd16;
    if (r == 3) return 5'd1;
    return 5'($urandom_range(1, 6));
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    dist_rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (dist_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected distance item: point %0d dist %0d last %0b", $time,
                 m_axis_tdata[3:0], m_axis_tdata[21:4], m_axis_tlast);
      end else begin
        want = dist_q.pop_front();
        if (m_axis_tdata[3:0] !== want.pt) begin
          errors++;
          $display("%0t: ref_point expected %0d actual %0d", $time, want.pt,
                   m_axis_tdata[3:0]);
        end
        if (m_axis_tdata[21:4] !== want.distance) begin
          errors++;
          $display("%0t: distance (point %0d) expected %0d actual %0d", $time, want.pt,
                   want.distance, m_axis_tdata[21:4]);
        end
        if (m_axis_tlast !== want.last) begin
          errors++;
          $display("%0t: last_of_query (point %0d) expected %0b actual %0b", $time,
                   want.pt, want.last, m_axis_tlast);
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back the core up
  initial begin
    m_axis_tready = 1'b0;
    stall_left = 0;
    long_hold_done = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 60) begin
        long_hold_done = 1;
        stall_left = 800;
        m_axis_tready <= 1'b0;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
        stall_left = $urandom_range(10, 40);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  // Switch between stretches with and without idling
  initial begin
    calm = 0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 199) == 0) calm = !calm;
    end
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    row_t rows[$];
    int   sent;
    int   since_cfg;
    int   r;
    int   nd;
    int   start;
    int   len;
    logic [3:0] hp;
    logic [3:0] hd;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = pwd_pkg::KIND_LOAD;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = pwd_pkg::CFG_POINTS_USED;
    cfg_data_i    = '0;
    errors        = 0;
    results_seen  = 0;
    points_raw    = 5'd16;
    dims_raw      = 5'd16;
    qnorm         = 0;
    foreach (norms[p]) begin
      norms[p] = 0;
      dots[p]  = 0;
    end
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every coordinate so no query ever reads an unwritten entry
    for (int p = 0; p < pwd_pkg::MaxPoints; p++)
      for (int d = 0; d < pwd_pkg::MaxDims; d++)
        send_item(pwd_pkg::KIND_LOAD, 4'(p), 4'(d), rand_coord());

    // Directed part: two points, one dimension, extreme coordinates
    write_cfg(pwd_pkg::CFG_POINTS_USED, 5'd2);
    write_cfg(pwd_pkg::CFG_DIMS_USED, 5'd1);
    rows = '{
      '{pwd_pkg::KIND_LOAD,  4'd0,  4'd0,  16'sh8000, 0, 0, 0},
      '{pwd_pkg::KIND_LOAD,  4'd1,  4'd0,  16'sh7FFF, 0, 0, 0},
      '{pwd_pkg::KIND_QUERY, 4'd15, 4'd0,  16'sh7FFF, 1, 65535, 0},
      '{pwd_pkg::KIND_QUERY, 4'd5,  4'd0,  16'sh8000, 1, 0, 65535},
      '{pwd_pkg::KIND_QUERY, 4'd0,  4'd0,  16'sh0000, 1, 32768, 32767},
      '{pwd_pkg::KIND_LOAD,  4'd15, 4'd15, 16'sh5555, 0, 0, 0},
      '{pwd_pkg::KIND_QUERY, 4'd10, 4'd3,  16'shAAAA, 0, 0, 0},
      '{pwd_pkg::KIND_QUERY, 4'd0,  4'd15, 16'sh7FFF, 0, 0, 0},
      '{pwd_pkg::KIND_QUERY, 4'd3,  4'd0,  16'sh0001, 1, 32769, 32766},
      '{pwd_pkg::KIND_LOAD,  4'd0,  4'd0,  16'sh0000, 0, 0, 0},
      '{pwd_pkg::KIND_LOAD,  4'd0,  4'd0,  16'sh0000, 0, 0, 0},
      '{pwd_pkg::KIND_QUERY, 4'd0,  4'd0,  16'shFFFF, 1, 1, 32768}
    };
    foreach (rows[i]) begin
      send_item(rows[i].kind, rows[i].pt, rows[i].dim, rows[i].value);
      if (rows[i].typed) begin
        dist_q[dist_q.size() - 2].distance = pwd_pkg::DistBits'(rows[i].dist0);
        dist_q[dist_q.size() - 1].distance = pwd_pkg::DistBits'(rows[i].dist1);
      end
    end
    write_cfg(pwd_pkg::CFG_POINTS_USED, 5'd31);
    write_cfg(pwd_pkg::CFG_DIMS_USED, 5'd0);
    send_item(pwd_pkg::KIND_QUERY, 4'd9, 4'd0, 16'sh8000);
    write_cfg(pwd_pkg::CFG_POINTS_USED, 5'd0);
    write_cfg(pwd_pkg::CFG_DIMS_USED, 5'd31);
    for (int d = 0; d < pwd_pkg::MaxDims; d++)
      send_item(pwd_pkg::KIND_QUERY, 4'($urandom), 4'(d), 16'sh8000);

    // Random part: mostly complete queries, some loads, broken sequences and saturation bursts
    sent = 0;
    since_cfg = 0;
    while (sent < RandItems) begin
      if (since_cfg > 60) begin
        write_cfg(pwd_pkg::CFG_POINTS_USED, rand_cfg());
        write_cfg(pwd_pkg::CFG_DIMS_USED, rand_cfg());
        since_cfg = 0;
      end
      nd = int'(clamp_used(dims_raw));
      r  = $urandom_range(0, 99);
      if (r < 25) begin
        send_item(pwd_pkg::KIND_LOAD, 4'($urandom), 4'($urandom), rand_coord());
        sent++;
        since_cfg++;
      end else if (r < 85) begin
        for (int d = 0; d < nd; d++)
          send_item(pwd_pkg::KIND_QUERY, 4'($urandom), 4'(d), rand_coord());
        sent += nd;
        since_cfg += nd;
      end else if (r < 93) begin
        start = $urandom_range(0, 15);
        len   = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          send_item(pwd_pkg::KIND_QUERY, 4'($urandom), 4'((start + k) % pwd_pkg::MaxDims),
                    rand_coord());
        sent += len;
        since_cfg += len;
      end else if (r < 98) begin
        send_item(pwd_pkg::KIND_QUERY, 4'($urandom),
                  4'($urandom_range(nd, 15) % pwd_pkg::MaxDims), rand_coord());
        sent++;
        since_cfg++;
      end else begin
        // Saturate a norm, then the query norm and dot products
        hp = 4'($urandom);
        hd = 4'($urandom_range(1, 15));
        for (int k = 0; k < 40; k++) send_item(pwd_pkg::KIND_LOAD, hp, hd, 16'sh8000);
        for (int k = 0; k < 40; k++)
          send_item(pwd_pkg::KIND_QUERY, 4'($urandom), 4'd1, 16'sh7FFF);
        send_item(pwd_pkg::KIND_QUERY, 4'($urandom), 4'(nd - 1), 16'sh7FFF);
        sent += 81;
        since_cfg += 81;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (dist_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && dist_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
